// File: rtl/pfc_pkg.sv
`timescale 1ns / 1ps
// Package for the payload response frame checker.
// Holds the verdict codes, register indexes, the sync constant and the shared structs.
// Depends on nothing.
package pfc_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h7E;

    typedef enum logic [2:0] {
        V_ACCEPT  = 3'd0,
        V_RESP    = 3'd1,
        V_RESEND  = 3'd2,
        V_FAIL    = 3'd3,
        V_SCIENCE = 3'd4
    } verdict_t;

    typedef enum logic [2:0] {
        REG_ACK_ID         = 3'd0,
        REG_IDENT_ID       = 3'd1,
        REG_NACK_ID        = 3'd2,
        REG_SYNC_ERR       = 3'd3,
        REG_CHECKSUM_ERR   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [7:0] ack_id;
        logic [7:0] ident_id;
        logic [7:0] nack_id;
        logic [7:0] sync_error_code;
        logic [7:0] checksum_error_code;
    } cfg_t;

    // Retry bookkeeping carried between frames.
    typedef struct packed {
        logic response_retry_pending;
        logic nack_seen;
    } retry_t;

endpackage

// File: rtl/payload_response_frame_checker_unit.sv
`timescale 1ns / 1ps
// Top level of the payload response frame checker.
// Depends on pfc_pkg and pfc_judge.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  rx_byte, frame_start
// out       output     out_valid/out_stall  verdict, response_id, error_byte
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A byte is held in the input register and is judged on its way into the result
// register, so a verdict is presented once the closing byte leaves the input register.
// One byte is accepted every cycle unless in_stall is raised by a held result.
// Reset clears the frame state, retry flags and valid flags and loads the default config.
// A stalled result holds; the input register keeps its byte while the result register
// is full and stalled, and in_stall is raised only then.
module payload_response_frame_checker_unit
    import pfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       frame_start,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] verdict,
    output logic [7:0] response_id,
    output logic [7:0] error_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    // Configuration registers.
    cfg_t cfg_reg;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // Frame state.
    logic       in_frame_reg,     in_frame_next;
    logic [8:0] byte_index_reg,   byte_index_next;
    logic [7:0] running_xor_reg,  running_xor_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] frame_id_reg,     frame_id_next;
    logic [7:0] frame_err_reg,    frame_err_next;
    retry_t     retry_reg,        retry_next;

    // Result register.
    logic       out_valid_reg;
    verdict_t   verdict_reg;
    logic [7:0] response_id_reg;
    logic [7:0] error_byte_reg;

    logic       accept;
    logic       advance;
    logic       produce;
    logic       link_error;
    logic [7:0] judge_id;
    logic [7:0] judge_err;
    verdict_t   judged;
    retry_t     judged_retry;

    // The input stage moves on whenever the result register is empty or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_frame_next     = in_frame_reg;
        byte_index_next   = byte_index_reg;
        running_xor_next  = running_xor_reg;
        frame_length_next = frame_length_reg;
        frame_id_next     = frame_id_reg;
        frame_err_next    = frame_err_reg;
        produce           = 1'b0;
        link_error        = 1'b0;
        judge_id          = frame_id_reg;
        judge_err         = frame_err_reg;

        if (in_start_reg)
        begin
            // A start byte drops any frame in progress.
            byte_index_next   = 9'd0;
            running_xor_next  = 8'd0;
            frame_length_next = 8'd0;
            frame_id_next     = 8'd0;
            frame_err_next    = 8'd0;
            if (in_byte_reg != SYNC_BYTE)
            begin
                in_frame_next = 1'b0;
                produce       = 1'b1;
                link_error    = 1'b1;
                judge_id      = 8'd0;
                judge_err     = 8'd0;
            end
            else
            begin
                in_frame_next   = 1'b1;
                byte_index_next = 9'd1;
            end
        end
        else if (in_frame_reg)
        begin
            if (byte_index_reg == 9'd1)
            begin
                frame_id_next = in_byte_reg;
            end
            else if (byte_index_reg == 9'd2)
            begin
                frame_length_next = in_byte_reg;
            end
            if (byte_index_reg == 9'd4)
            begin
                frame_err_next = in_byte_reg;
            end
            judge_err = frame_err_next;

            // The checksum byte sits at index length plus four; length is settled by then.
            if (byte_index_reg >= 9'd3 &&
                byte_index_reg == ({1'b0, frame_length_reg} + 9'd4))
            begin
                in_frame_next   = 1'b0;
                byte_index_next = 9'd0;
                produce         = 1'b1;
                link_error      = (in_byte_reg != running_xor_reg);
            end
            else
            begin
                running_xor_next = running_xor_reg ^ in_byte_reg;
                byte_index_next  = byte_index_reg + 9'd1;
            end
        end
    end

    pfc_judge u_judge (
        .cfg        (cfg_reg),
        .link_error (link_error),
        .frame_id   (judge_id),
        .error_byte (judge_err),
        .retry      (retry_reg),
        .verdict    (judged),
        .retry_next (judged_retry)
    );

    assign retry_next = produce ? judged_retry : retry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_id              <= 8'd2;
            cfg_reg.ident_id            <= 8'd4;
            cfg_reg.nack_id             <= 8'd3;
            cfg_reg.sync_error_code     <= 8'd1;
            cfg_reg.checksum_error_code <= 8'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ACK_ID:       cfg_reg.ack_id              <= cfg_data;
                REG_IDENT_ID:     cfg_reg.ident_id            <= cfg_data;
                REG_NACK_ID:      cfg_reg.nack_id             <= cfg_data;
                REG_SYNC_ERR:     cfg_reg.sync_error_code     <= cfg_data;
                REG_CHECKSUM_ERR: cfg_reg.checksum_error_code <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= rx_byte;
            in_start_reg <= frame_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg     <= 1'b0;
            byte_index_reg   <= 9'd0;
            running_xor_reg  <= 8'd0;
            frame_length_reg <= 8'd0;
            frame_id_reg     <= 8'd0;
            frame_err_reg    <= 8'd0;
            retry_reg        <= '0;
        end
        else if (advance)
        begin
            in_frame_reg     <= in_frame_next;
            byte_index_reg   <= byte_index_next;
            running_xor_reg  <= running_xor_next;
            frame_length_reg <= frame_length_next;
            frame_id_reg     <= frame_id_next;
            frame_err_reg    <= frame_err_next;
            retry_reg        <= retry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            verdict_reg     <= judged;
            response_id_reg <= judge_id;
            error_byte_reg  <= judge_err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign verdict     = verdict_reg;
    assign response_id = response_id_reg;
    assign error_byte  = error_byte_reg;

    // Inside a frame the index is never zero, and outside it always is.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg == (byte_index_reg != 9'd0))
        else $error("frame flag and byte index disagree");

    // The longest frame closes at index 259.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= 9'd259)
        else $error("byte index ran past the longest frame");

    // A full input register with a held result must push back on the source.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && out_stall |-> in_stall)
        else $error("input not stalled while result is held");

    // A stalled result stays presented with the same verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(verdict_reg))
        else $error("held result lost or changed");

endmodule

// File: rtl/pfc_judge.sv
`timescale 1ns / 1ps
// Verdict decision for one finished (or failed) response frame.
// Depends on pfc_pkg for the verdict codes, the register struct and the retry struct.
module pfc_judge
    import pfc_pkg::*;
(
    input  cfg_t       cfg,
    input  logic       link_error,
    input  logic [7:0] frame_id,
    input  logic [7:0] error_byte,
    input  retry_t     retry,
    output verdict_t   verdict,
    output retry_t     retry_next
);

    always_comb
    begin
        retry_next = retry;
        verdict    = V_SCIENCE;
        if (link_error)
        begin
            // A bad sync or checksum asks again once, then fails.
            if (!retry.response_retry_pending)
            begin
                retry_next.response_retry_pending = 1'b1;
                verdict = V_RESP;
            end
            else
            begin
                retry_next.response_retry_pending = 1'b0;
                verdict = V_FAIL;
            end
        end
        else if (frame_id == cfg.ack_id || frame_id == cfg.ident_id)
        begin
            verdict = V_ACCEPT;
        end
        else if (frame_id == cfg.nack_id)
        begin
            if (error_byte == cfg.sync_error_code || error_byte == cfg.checksum_error_code)
            begin
                if (retry.nack_seen)
                begin
                    retry_next.nack_seen = 1'b0;
                    verdict = V_FAIL;
                end
                else
                begin
                    retry_next.nack_seen = 1'b1;
                    verdict = V_RESEND;
                end
            end
            else
            begin
                verdict = V_FAIL;
            end
        end
    end

endmodule
